### rtl/core/keyboard_scancode_to_ascii_assert.svh
// Assertion macros shared by the scan code translator RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef KEYBOARD_SCANCODE_TO_ASCII_ASSERT_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_ASSERT_SVH

// Same-cycle implication.
`define KSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/kbd_sc2a_pkg.sv
// Package for the scan code set 1 to ASCII translator.
// Holds code constants, the key maps and the translation result type; no dependencies.
package kbd_sc2a_pkg;

    localparam int CODE_W = 8;
    localparam int CHAR_W = 7;

    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [CODE_W-1:0] SC_CAPS_BREAK   = 8'hBA;
    localparam logic [CODE_W-1:0] SC_MAP_FIRST    = 8'h01;
    localparam logic [CODE_W-1:0] SC_MAP_LAST     = 8'h35;
    localparam logic [CODE_W-1:0] SC_SPACE        = 8'h39;
    localparam int                SC_RELEASE_BIT  = 7;

    localparam logic [CHAR_W-1:0] CH_NONE      = 7'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 7'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE     = 7'h7E;
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 7'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A   = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_CASE_BIT  = 7'h20;

    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] ascii_char;
        logic              echo_flag;
        logic              shift_next;
        logic              caps_next;
    } xlate_t;

    // Unshifted map, indexed by the low six bits of a make code.
    function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            6'h02: ch = 7'h31;
            6'h03: ch = 7'h32;
            6'h04: ch = 7'h33;
            6'h05: ch = 7'h34;
            6'h06: ch = 7'h35;
            6'h07: ch = 7'h36;
            6'h08: ch = 7'h37;
            6'h09: ch = 7'h38;
            6'h0A: ch = 7'h39;
            6'h0B: ch = 7'h30;
            6'h0C: ch = 7'h2D;
            6'h0D: ch = 7'h3D;
            6'h0E: ch = 7'h08;
            6'h0F: ch = 7'h09;
            6'h10: ch = 7'h71;
            6'h11: ch = 7'h77;
            6'h12: ch = 7'h65;
            6'h13: ch = 7'h72;
            6'h14: ch = 7'h74;
            6'h15: ch = 7'h79;
            6'h16: ch = 7'h75;
            6'h17: ch = 7'h69;
            6'h18: ch = 7'h6F;
            6'h19: ch = 7'h70;
            6'h1A: ch = 7'h5B;
            6'h1B: ch = 7'h5D;
            6'h1C: ch = 7'h0A;
            6'h1E: ch = 7'h61;
            6'h1F: ch = 7'h73;
            6'h20: ch = 7'h64;
            6'h21: ch = 7'h66;
            6'h22: ch = 7'h67;
            6'h23: ch = 7'h68;
            6'h24: ch = 7'h6A;
            6'h25: ch = 7'h6B;
            6'h26: ch = 7'h6C;
            6'h27: ch = 7'h3B;
            6'h28: ch = 7'h27;
            6'h29: ch = 7'h60;
            6'h2B: ch = 7'h5C;
            6'h2C: ch = 7'h7A;
            6'h2D: ch = 7'h78;
            6'h2E: ch = 7'h63;
            6'h2F: ch = 7'h76;
            6'h30: ch = 7'h62;
            6'h31: ch = 7'h6E;
            6'h32: ch = 7'h6D;
            6'h33: ch = 7'h2C;
            6'h34: ch = 7'h2E;
            6'h35: ch = 7'h2F;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    // Shifted map, same indexing.
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [5:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            6'h02: ch = 7'h21;
            6'h03: ch = 7'h40;
            6'h04: ch = 7'h23;
            6'h05: ch = 7'h24;
            6'h06: ch = 7'h25;
            6'h07: ch = 7'h5E;
            6'h08: ch = 7'h26;
            6'h09: ch = 7'h2A;
            6'h0A: ch = 7'h28;
            6'h0B: ch = 7'h29;
            6'h0C: ch = 7'h5F;
            6'h0D: ch = 7'h2B;
            6'h0E: ch = 7'h08;
            6'h0F: ch = 7'h09;
            6'h10: ch = 7'h51;
            6'h11: ch = 7'h57;
            6'h12: ch = 7'h45;
            6'h13: ch = 7'h52;
            6'h14: ch = 7'h54;
            6'h15: ch = 7'h59;
            6'h16: ch = 7'h55;
            6'h17: ch = 7'h49;
            6'h18: ch = 7'h4F;
            6'h19: ch = 7'h50;
            6'h1A: ch = 7'h7B;
            6'h1B: ch = 7'h7D;
            6'h1C: ch = 7'h0A;
            6'h1E: ch = 7'h41;
            6'h1F: ch = 7'h53;
            6'h20: ch = 7'h44;
            6'h21: ch = 7'h46;
            6'h22: ch = 7'h47;
            6'h23: ch = 7'h48;
            6'h24: ch = 7'h4A;
            6'h25: ch = 7'h4B;
            6'h26: ch = 7'h4C;
            6'h27: ch = 7'h3A;
            6'h28: ch = 7'h22;
            6'h29: ch = 7'h7E;
            6'h2B: ch = 7'h7C;
            6'h2C: ch = 7'h5A;
            6'h2D: ch = 7'h58;
            6'h2E: ch = 7'h43;
            6'h2F: ch = 7'h56;
            6'h30: ch = 7'h42;
            6'h31: ch = 7'h4E;
            6'h32: ch = 7'h4D;
            6'h33: ch = 7'h3C;
            6'h34: ch = 7'h3E;
            6'h35: ch = 7'h3F;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

### rtl/core/kbd_sc2a_code_if.sv
// Scan code channel: valid/ready handshake carrying one scan code byte per item.
// Depends on kbd_sc2a_pkg for the code width.
interface kbd_sc2a_code_if;
    logic                              valid;
    logic                              ready;
    logic [kbd_sc2a_pkg::CODE_W-1:0]   scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

### rtl/core/kbd_sc2a_char_if.sv
// Character channel: valid/ready handshake carrying one ASCII character and echo flag.
// Depends on kbd_sc2a_pkg for the character width.
interface kbd_sc2a_char_if;
    logic                              valid;
    logic                              ready;
    logic [kbd_sc2a_pkg::CHAR_W-1:0]   ascii_char;
    logic                              echo_flag;

    modport source (output valid, output ascii_char, output echo_flag, input ready);
    modport sink   (input valid, input ascii_char, input echo_flag, output ready);
endinterface

### rtl/core/kbd_sc2a_xlate.sv
// Combinational scan code translation and shift/caps flag update.
// Depends on kbd_sc2a_pkg (maps, code constants, xlate_t).
module kbd_sc2a_xlate (
    input  logic [kbd_sc2a_pkg::CODE_W-1:0] code,
    input  logic                            shift,
    input  logic                            caps,
    output kbd_sc2a_pkg::xlate_t            result
);

    logic                            release_key;
    logic                            in_map;
    logic [kbd_sc2a_pkg::CHAR_W-1:0] map_ch;
    logic [kbd_sc2a_pkg::CHAR_W-1:0] case_ch;
    logic [kbd_sc2a_pkg::CHAR_W-1:0] ch;
    logic                            is_letter;

    assign release_key = code[kbd_sc2a_pkg::SC_RELEASE_BIT];
    assign in_map      = (code >= kbd_sc2a_pkg::SC_MAP_FIRST)
                         && (code <= kbd_sc2a_pkg::SC_MAP_LAST);

    always_comb
    begin
        if (shift)
        begin
            map_ch = kbd_sc2a_pkg::shifted_char(code[5:0]);
        end
        else
        begin
            map_ch = kbd_sc2a_pkg::plain_char(code[5:0]);
        end
    end

    assign is_letter = ((map_ch >= kbd_sc2a_pkg::CH_LOWER_A) && (map_ch <= kbd_sc2a_pkg::CH_LOWER_Z))
                    || ((map_ch >= kbd_sc2a_pkg::CH_UPPER_A) && (map_ch <= kbd_sc2a_pkg::CH_UPPER_Z));
    assign case_ch   = (caps && is_letter) ? (map_ch ^ kbd_sc2a_pkg::CH_CASE_BIT) : map_ch;

    always_comb
    begin
        if (release_key)
        begin
            ch = kbd_sc2a_pkg::CH_NONE;
        end
        else if (in_map)
        begin
            ch = case_ch;
        end
        else if (code == kbd_sc2a_pkg::SC_SPACE)
        begin
            ch = kbd_sc2a_pkg::CH_SPACE;
        end
        else
        begin
            ch = kbd_sc2a_pkg::CH_NONE;
        end
    end

    always_comb
    begin
        result.ascii_char = ch;
        result.has_char   = (ch != kbd_sc2a_pkg::CH_NONE);
        result.echo_flag  = (ch >= kbd_sc2a_pkg::CH_SPACE) && (ch <= kbd_sc2a_pkg::CH_TILDE);
        result.shift_next = shift;
        result.caps_next  = caps;
        if ((code == kbd_sc2a_pkg::SC_LSHIFT_MAKE) || (code == kbd_sc2a_pkg::SC_RSHIFT_MAKE))
        begin
            result.shift_next = 1'b1;
        end
        else if ((code == kbd_sc2a_pkg::SC_LSHIFT_BREAK)
                 || (code == kbd_sc2a_pkg::SC_RSHIFT_BREAK))
        begin
            result.shift_next = 1'b0;
        end
        else if (code == kbd_sc2a_pkg::SC_CAPS_BREAK)
        begin
            result.caps_next = ~caps;
        end
    end

endmodule

### rtl/core/keyboard_scancode_to_ascii.sv
// Top level: scan code set 1 to ASCII translator with shift and caps lock tracking.
// Depends on kbd_sc2a_pkg, kbd_sc2a_code_if, kbd_sc2a_char_if, kbd_sc2a_xlate
// and keyboard_scancode_to_ascii_assert.svh.
//
//   port    dir   item
//   scan    in    scan_code (8b)
//   ascii   out   ascii_char (7b), echo_flag (1b)
//
// One item per cycle sustained while the output is not stalled: input register, table lookup, output register.
// ascii valid rises when a result is loaded from the input into the output register.
// Codes giving no character update the flags and are dropped without a result.
// A stalled output holds its item; the input register still drains no-character items.
// Reset clears both flags and all valid bits.
`include "keyboard_scancode_to_ascii_assert.svh"

module keyboard_scancode_to_ascii (
    input  logic                   clk,
    input  logic                   rst_n,
    kbd_sc2a_code_if.sink          scan,
    kbd_sc2a_char_if.source        ascii
);

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [kbd_sc2a_pkg::CODE_W-1:0] s1_code_reg;
    logic                            shift_reg;
    logic                            shift_next;
    logic                            caps_reg;
    logic                            caps_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [kbd_sc2a_pkg::CHAR_W-1:0] out_char_reg;
    logic                            out_echo_reg;

    kbd_sc2a_pkg::xlate_t            xl;
    logic                            scan_fire;
    logic                            out_free;
    logic                            s1_move;

    kbd_sc2a_xlate u_xlate (
        .code   (s1_code_reg),
        .shift  (shift_reg),
        .caps   (caps_reg),
        .result (xl)
    );

    assign out_free   = !out_valid_reg || ascii.ready;
    assign s1_move    = s1_valid_reg && (out_free || !xl.has_char);
    assign scan.ready = !s1_valid_reg || s1_move;
    assign scan_fire  = scan.valid && scan.ready;

    always_comb
    begin
        if (scan_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            shift_next = xl.shift_next;
            caps_next  = xl.caps_next;
        end
        else
        begin
            shift_next = shift_reg;
            caps_next  = caps_reg;
        end

        if (s1_move && xl.has_char)
        begin
            out_valid_next = 1'b1;
        end
        else if (ascii.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            shift_reg     <= shift_next;
            caps_reg      <= caps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_fire)
        begin
            s1_code_reg <= scan.scan_code;
        end
        if (s1_move && xl.has_char)
        begin
            out_char_reg <= xl.ascii_char;
            out_echo_reg <= xl.echo_flag;
        end
    end

    assign ascii.valid      = out_valid_reg;
    assign ascii.ascii_char = out_char_reg;
    assign ascii.echo_flag  = out_echo_reg;

    `KSA_ASSERT_NEXT(a_accept_loads, scan_fire, s1_valid_reg,
        "accepted item not held in input register")
    `KSA_ASSERT_NOW(a_out_nonzero, out_valid_reg, out_char_reg != kbd_sc2a_pkg::CH_NONE,
        "zero character offered")
    `KSA_ASSERT_NEXT(a_shift_make, s1_move && (s1_code_reg == kbd_sc2a_pkg::SC_LSHIFT_MAKE),
        shift_reg, "shift make did not set shift")
    `KSA_ASSERT_NEXT(a_caps_toggle, s1_move && (s1_code_reg == kbd_sc2a_pkg::SC_CAPS_BREAK),
        caps_reg != $past(caps_reg), "caps release did not toggle")
    `KSA_ASSERT_NEXT(a_caps_hold,
        !(s1_move && (s1_code_reg == kbd_sc2a_pkg::SC_CAPS_BREAK)),
        $stable(caps_reg), "caps changed without caps release")

endmodule
